// ----- hdl/pgnc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pgnc_pkg: shared types and constants
// Widths, operation codes, status codes and sequencer states for the
// periodic grid nearest cell search core.
// ---------------------------------------------------------------------------
package pgnc_pkg;
	localparam int MAX_CELLS  = 4096;
	localparam int NG_MAX     = 16;
	localparam int BIN_CAP    = 8;
	localparam int COORD_BITS = 16;

	localparam int ID_W   = $clog2(MAX_CELLS);
	localparam int CNT_W  = ID_W + 1;
	localparam int NGB_W  = $clog2(NG_MAX);
	localparam int NGV_W  = NGB_W + 1;
	localparam int NBINS  = NG_MAX * NG_MAX * NG_MAX;
	localparam int BIN_W  = $clog2(NBINS);
	localparam int SLOT_W = $clog2(BIN_CAP);
	localparam int FILL_W = SLOT_W + 1;
	localparam int PT_W   = 3 * COORD_BITS;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = SQ_W + 2;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BIN_FULL  = 2'd1,
		ST_TBL_FULL  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WIPE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_WR,
		S_Q_BIN,
		S_Q_FILL,
		S_Q_SLOT,
		S_Q_PT,
		S_Q_AX,
		S_Q_CMP,
		S_DONE
	} state_t;
endpackage

// ----- hdl/pgnc_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pgnc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module pgnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hdl/pgnc_axis_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pgnc_axis_unit: shared minimum-image square
// Wraps one axis difference into the half box and squares it.
// ---------------------------------------------------------------------------
module pgnc_axis_unit
	import pgnc_pkg::*;
(
	input  logic [COORD_BITS-1:0] a,
	input  logic [COORD_BITS-1:0] b,
	output logic [SQ_W-1:0]       sq
);
	logic [COORD_BITS-1:0] d;
	logic [COORD_BITS-1:0] m;

	// modular difference; the magnitude is the shorter way around
	always_comb begin
		d = a - b;
		if (d[COORD_BITS-1]) begin
			m = COORD_BITS'(0) - d;
		end else begin
			m = d;
		end
		sq = SQ_W'(m) * SQ_W'(m);
	end
endmodule

// ----- hdl/periodic_grid_nearest_cell_search_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_grid_nearest_cell_search_core: nearest cell search, periodic grid
// One transaction at a time: insert, query, clear or the unused code. Busy is high
// meanwhile, next start is taken in the done cycle. The fill, slot and point
// memories are single-port, and the one squaring unit is used once per axis.
// Reset: a clearing pass over all 4096 bins empties the bin fill memory, busy
// high, no done.
// ---------------------------------------------------------------------------
module periodic_grid_nearest_cell_search_core
	import pgnc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            operation,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	input  logic [COORD_BITS-1:0] coord_z,
	output logic                  done,
	output logic [1:0]            status,
	output logic [ID_W-1:0]       cell_id,
	output logic [31:0]           dist_sq
);
	state_t state_q, state_d;
	logic [4:0]            grid_q;
	logic [NGV_W-1:0]      ng_q;
	logic [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic [NGB_W-1:0]      bx_q, by_q, bz_q;
	logic [NGB_W-1:0]      gx_q, gy_q, gz_q;
	logic [1:0]            ix_q, iy_q, iz_q;
	logic [CNT_W-1:0]      cells_q;
	logic [BIN_W-1:0]      wipe_q;
	logic                  init_q;
	logic [FILL_W-1:0]     slot_q;
	logic [ID_W-1:0]       cand_q;
	logic [1:0]            ax_q;
	logic [DIST_W-1:0]     acc_q;
	logic                  found_q;
	logic [DIST_W-1:0]     best_q;
	logic [ID_W-1:0]       best_id_q;
	logic [1:0]            res_st_q;
	logic [ID_W-1:0]       res_id_q;
	logic [31:0]           res_d_q;
	logic                  done_q;

	// memories
	logic              fill_we;
	logic [BIN_W-1:0]  fill_addr;
	logic [FILL_W-1:0] fill_wd, fill_rd;
	logic              slot_we;
	logic [BIN_W+SLOT_W-1:0] slot_addr;
	logic [ID_W-1:0]   slot_rd;
	logic              pt_we;
	logic [ID_W-1:0]   pt_addr;
	logic [PT_W-1:0]   pt_rd;
	logic [PT_W-1:0]   pt_q;

	pgnc_ram #(.WIDTH(FILL_W), .DEPTH(NBINS)) u_fill (
		.clk(clk), .we(fill_we), .addr(fill_addr), .wdata(fill_wd), .rdata(fill_rd));
	pgnc_ram #(.WIDTH(ID_W), .DEPTH(NBINS * BIN_CAP)) u_slot (
		.clk(clk), .we(slot_we), .addr(slot_addr), .wdata(cells_q[ID_W-1:0]),
		.rdata(slot_rd));
	pgnc_ram #(.WIDTH(PT_W), .DEPTH(MAX_CELLS)) u_pt (
		.clk(clk), .we(pt_we), .addr(pt_addr), .wdata({px_q, py_q, pz_q}),
		.rdata(pt_rd));

	logic [COORD_BITS-1:0] ax_a, ax_b;
	logic [SQ_W-1:0]       ax_sq;
	pgnc_axis_unit u_axis (.a(ax_a), .b(ax_b), .sq(ax_sq));

	// bin of an incoming coordinate
	function automatic logic [NGB_W-1:0] bin_of(input logic [COORD_BITS-1:0] c,
		input logic [NGV_W-1:0] ng);
		logic [COORD_BITS+NGV_W-1:0] p;
		p = (COORD_BITS+NGV_W)'(c) * (COORD_BITS+NGV_W)'(ng);
		return NGB_W'(p >> COORD_BITS);
	endfunction

	// neighbor bin with periodic wrap, offset 0..2 meaning -1..+1
	function automatic logic [NGB_W-1:0] nb(input logic [NGB_W-1:0] b,
		input logic [1:0] i, input logic [NGV_W-1:0] ng);
		logic [NGV_W:0] t;
		t = (NGV_W+1)'(b) + (NGV_W+1)'(ng) - (NGV_W+1)'(1) + (NGV_W+1)'(i);
		if (t >= (NGV_W+1)'(ng)) t = t - (NGV_W+1)'(ng);
		if (t >= (NGV_W+1)'(ng)) t = t - (NGV_W+1)'(ng);
		return NGB_W'(t);
	endfunction

	logic [BIN_W-1:0] home_bin, scan_bin;
	assign home_bin = {bx_q, by_q, bz_q};
	assign scan_bin = {gx_q, gy_q, gz_q};
	logic last_bin;
	assign last_bin = (ix_q == 2'd2) && (iy_q == 2'd2) && (iz_q == 2'd2);
	logic [DIST_W-1:0] d2;
	assign d2 = acc_q + DIST_W'(ax_sq);

	// first axis cycle loads the point, then x, y and z in turn
	always_comb begin
		unique case (ax_q)
			2'd1:    ax_a = pt_q[PT_W-1 -: COORD_BITS];
			2'd2:    ax_a = pt_q[2*COORD_BITS-1 -: COORD_BITS];
			default: ax_a = pt_q[COORD_BITS-1:0];
		endcase
		unique case (ax_q)
			2'd1:    ax_b = px_q;
			2'd2:    ax_b = py_q;
			default: ax_b = pz_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op_t'(operation))
						OP_INSERT: state_d = S_INS_RD;
						OP_QUERY:  state_d = S_Q_BIN;
						OP_CLEAR:  state_d = S_WIPE;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_WIPE: begin
				if (wipe_q == BIN_W'(NBINS - 1)) state_d = init_q ? S_IDLE : S_DONE;
			end
			S_INS_RD:  state_d = S_INS_CHK;
			S_INS_CHK: begin
				if (cells_q >= CNT_W'(MAX_CELLS) || fill_rd >= FILL_W'(BIN_CAP)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR:  state_d = S_DONE;
			S_Q_BIN:   state_d = S_Q_FILL;
			S_Q_FILL:  state_d = S_Q_SLOT;
			S_Q_SLOT: begin
				if (slot_q >= fill_rd) begin
					state_d = last_bin ? S_DONE : S_Q_BIN;
				end else begin
					state_d = S_Q_PT;
				end
			end
			S_Q_PT:    state_d = S_Q_AX;
			S_Q_AX:    state_d = (ax_q == 2'd2) ? S_Q_CMP : S_Q_AX;
			S_Q_CMP:   state_d = S_Q_SLOT;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		fill_we   = 1'b0;
		fill_addr = home_bin;
		fill_wd   = fill_rd + FILL_W'(1);
		slot_we   = 1'b0;
		slot_addr = {home_bin, fill_rd[SLOT_W-1:0]};
		pt_we     = 1'b0;
		pt_addr   = cells_q[ID_W-1:0];
		unique case (state_q)
			S_WIPE: begin
				fill_we   = 1'b1;
				fill_addr = wipe_q;
				fill_wd   = '0;
			end
			S_INS_RD: begin
				fill_addr = {bin_of(px_q, ng_q), bin_of(py_q, ng_q), bin_of(pz_q, ng_q)};
			end
			S_INS_WR: begin
				fill_we = 1'b1;
				slot_we = 1'b1;
				pt_we   = 1'b1;
			end
			S_Q_BIN, S_Q_FILL, S_Q_AX, S_Q_CMP: fill_addr = scan_bin;
			S_Q_SLOT: begin
				fill_addr = scan_bin;
				slot_addr = {scan_bin, slot_q[SLOT_W-1:0]};
			end
			S_Q_PT: begin
				fill_addr = scan_bin;
				pt_addr   = slot_rd;
			end
			default: ;
		endcase
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign status  = res_st_q;
	assign cell_id = res_id_q;
	assign dist_sq = res_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			grid_q  <= 5'd1;
			cells_q <= '0;
			wipe_q  <= '0;
			init_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (cfg_we) grid_q <= cfg_wdata;
			if (state_q == S_WIPE) wipe_q <= wipe_q + BIN_W'(1);
			if (state_q == S_WIPE && wipe_q == BIN_W'(NBINS - 1)) init_q <= 1'b0;
			if (state_q == S_IDLE && start && op_t'(operation) == OP_CLEAR) begin
				cells_q <= '0;
			end
			if (state_q == S_INS_WR) cells_q <= cells_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			if (grid_q == 5'd0) ng_q <= NGV_W'(1);
			else if (grid_q > 5'(NG_MAX)) ng_q <= NGV_W'(NG_MAX);
			else ng_q <= NGV_W'(grid_q);
			px_q <= coord_x;
			py_q <= coord_y;
			pz_q <= coord_z;
			ix_q <= '0;
			iy_q <= '0;
			iz_q <= '0;
			found_q  <= 1'b0;
			res_st_q <= ST_OK;
			res_id_q <= '0;
			res_d_q  <= '0;
		end
		if (state_q == S_INS_RD || state_q == S_Q_BIN) begin
			if (state_q == S_INS_RD) begin
				bx_q <= bin_of(px_q, ng_q);
				by_q <= bin_of(py_q, ng_q);
				bz_q <= bin_of(pz_q, ng_q);
			end
		end
		unique case (state_q)
			S_INS_CHK: begin
				if (cells_q >= CNT_W'(MAX_CELLS)) res_st_q <= ST_TBL_FULL;
				else if (fill_rd >= FILL_W'(BIN_CAP)) res_st_q <= ST_BIN_FULL;
				else res_id_q <= cells_q[ID_W-1:0];
			end
			S_Q_BIN: begin
				if (ix_q == 2'd0 && iy_q == 2'd0 && iz_q == 2'd0) begin
					bx_q <= bin_of(px_q, ng_q);
					by_q <= bin_of(py_q, ng_q);
					bz_q <= bin_of(pz_q, ng_q);
					gx_q <= nb(bin_of(px_q, ng_q), 2'd0, ng_q);
					gy_q <= nb(bin_of(py_q, ng_q), 2'd0, ng_q);
					gz_q <= nb(bin_of(pz_q, ng_q), 2'd0, ng_q);
				end else begin
					gx_q <= nb(bx_q, ix_q, ng_q);
					gy_q <= nb(by_q, iy_q, ng_q);
					gz_q <= nb(bz_q, iz_q, ng_q);
				end
			end
			S_Q_FILL: slot_q <= '0;
			S_Q_SLOT: begin
				if (slot_q >= fill_rd) begin
					if (iz_q == 2'd2) begin
						iz_q <= '0;
						if (iy_q == 2'd2) begin
							iy_q <= '0;
							ix_q <= ix_q + 2'd1;
						end else begin
							iy_q <= iy_q + 2'd1;
						end
					end else begin
						iz_q <= iz_q + 2'd1;
					end
					if (last_bin) begin
						if (found_q) begin
							res_id_q <= best_id_q;
							res_d_q  <= 32'(best_q);
						end else begin
							res_st_q <= ST_NOT_FOUND;
						end
					end
				end
			end
			S_Q_PT: begin
				cand_q <= slot_rd;
				ax_q   <= '0;
				acc_q  <= '0;
			end
			S_Q_AX: begin
				if (ax_q == 2'd0) pt_q <= pt_rd;
				else begin
					acc_q <= d2;
					ax_q  <= ax_q + 2'd1;
				end
				if (ax_q == 2'd0) ax_q <= 2'd1;
			end
			S_Q_CMP: begin
				if (!found_q || d2 < best_q) begin
					found_q   <= 1'b1;
					best_q    <= d2;
					best_id_q <= cand_q;
				end
				slot_q <= slot_q + FILL_W'(1);
			end
			default: ;
		endcase
	end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: periodic grid nearest cell search testbench
// Drives inserts, queries, clears and the unused code under several grid sizes and checks
// every result against an in-bench grid and nearest-cell predictor.
// ---------------------------------------------------------------------------
module tb;
	import pgnc_pkg::*;

	class cell_grid_board;
		logic [15:0] pts [MAX_CELLS][3];
		int unsigned n_cells;
		int unsigned fill [NBINS];
		int unsigned slots [NBINS][BIN_CAP];
		logic [4:0] ng_reg;
		logic [1:0] exp_st [$];
		logic [11:0] exp_id [$];
		logic [31:0] exp_d [$];
		int errors;

		function new();
			n_cells = 0;
			ng_reg = 5'd1;
			errors = 0;
			foreach (fill[i]) fill[i] = 0;
		endfunction

		function int unsigned eff_ng();
			if (ng_reg == 0) return 1;
			if (ng_reg > NG_MAX) return NG_MAX;
			return int'(ng_reg);
		endfunction

		function longint unsigned axis_sq(logic [15:0] a, logic [15:0] b);
			longint d;
			d = longint'(a) - longint'(b);
			if (d > 32768) d -= 65536;
			if (d < -32768) d += 65536;
			return d * d;
		endfunction

		function void note(op_t op, logic [15:0] p [3]);
			int unsigned ng, bn [3], f, gx, gy, gz, c;
			logic [1:0] st;
			logic [11:0] id;
			longint unsigned best, d2;
			bit found;
			ng = eff_ng();
			for (int k = 0; k < 3; k++) bn[k] = (p[k] * ng) >> COORD_BITS;
			st = ST_OK; id = 0; best = 0; found = 0;
			case (op)
				OP_INSERT: begin
					f = (bn[0] * NG_MAX + bn[1]) * NG_MAX + bn[2];
					if (n_cells >= MAX_CELLS) st = ST_TBL_FULL;
					else if (fill[f] >= BIN_CAP) st = ST_BIN_FULL;
					else begin
						id = 12'(n_cells);
						for (int k = 0; k < 3; k++) pts[n_cells][k] = p[k];
						slots[f][fill[f]] = n_cells;
						fill[f]++;
						n_cells++;
					end
				end
				OP_QUERY: begin
					for (int i = 0; i < 3; i++) begin
						gx = (bn[0] + ng - 1 + i) % ng;
						for (int j = 0; j < 3; j++) begin
							gy = (bn[1] + ng - 1 + j) % ng;
							for (int l = 0; l < 3; l++) begin
								gz = (bn[2] + ng - 1 + l) % ng;
								f = (gx * NG_MAX + gy) * NG_MAX + gz;
								for (int q = 0; q < fill[f]; q++) begin
									c = slots[f][q];
									d2 = axis_sq(pts[c][0], p[0]) + axis_sq(pts[c][1], p[1])
										+ axis_sq(pts[c][2], p[2]);
									if (!found || d2 < best) begin
										found = 1; best = d2; id = 12'(c);
									end
								end
							end
						end
					end
					if (!found) st = ST_NOT_FOUND;
				end
				OP_CLEAR: begin
					n_cells = 0;
					foreach (fill[i]) fill[i] = 0;
				end
				default: ;
			endcase
			exp_st.push_back(st);
			exp_id.push_back(id);
			exp_d.push_back(best[31:0]);
		endfunction

		function void check(logic [1:0] st, logic [11:0] id, logic [31:0] d);
			if (exp_st.size() == 0) begin
				$display("%0t: unexpected result st=%0d id=%0d d=%0d", $time, st, id, d);
				errors++;
				return;
			end
			if (st !== exp_st[0]) begin
				$display("%0t: status exp %0d got %0d", $time, exp_st[0], st);
				errors++;
			end
			if (id !== exp_id[0]) begin
				$display("%0t: cell_id exp %0d got %0d", $time, exp_id[0], id);
				errors++;
			end
			if (d !== exp_d[0]) begin
				$display("%0t: dist_sq exp %0d got %0d", $time, exp_d[0], d);
				errors++;
			end
			void'(exp_st.pop_front());
			void'(exp_id.pop_front());
			void'(exp_d.pop_front());
		endfunction
	endclass

	logic clk = 0, arst_n = 0, cfg_we = 0, start = 0;
	logic [4:0] cfg_wdata = 0;
	logic [1:0] operation = 0;
	logic [15:0] coord_x = 0, coord_y = 0, coord_z = 0;
	logic busy, done;
	logic [1:0] status;
	logic [11:0] cell_id;
	logic [31:0] dist_sq;
	int idle_pct;
	cell_grid_board board;
	logic [15:0] anchor [3];

	periodic_grid_nearest_cell_search_core dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk)
		if (done) board.check(status, cell_id, dist_sq);

	task automatic send(op_t op, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		logic [15:0] p [3];
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		start <= 1; operation <= op; coord_x <= x; coord_y <= y; coord_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		p[0] = x; p[1] = y; p[2] = z;
		board.note(op, p);
		start <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.exp_st.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_grid(logic [4:0] v);
		drain();
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		board.ng_reg = v;
		@(posedge clk);
	endtask

	task automatic rand_item();
		int r;
		logic [15:0] x, y, z;
		r = $urandom_range(99);
		if (r < 40) begin
			x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
		end else begin
			// cluster near an anchor point, across the periodic seam too
			x = anchor[0] + 16'($urandom_range(0, 4000)) - 16'd2000;
			y = anchor[1] + 16'($urandom_range(0, 4000)) - 16'd2000;
			z = anchor[2] + 16'($urandom_range(0, 4000)) - 16'd2000;
		end
		r = $urandom_range(99);
		if (r < 45) send(OP_INSERT, x, y, z);
		else if (r < 95) send(OP_QUERY, x, y, z);
		else if (r < 97) send(OP_NONE, x, y, z);
		else send(OP_CLEAR, x, y, z);
	endtask

	initial begin
		board = new();
		idle_pct = 14;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send(OP_QUERY, 0, 0, 0);
		send(OP_INSERT, 0, 0, 0);
		send(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(OP_QUERY, 16'h8000, 16'h8000, 16'h8000);
		send(OP_QUERY, 16'hFFFF, 0, 16'h7FFF);
		send(OP_NONE, 16'h1234, 16'h5678, 16'h9ABC);
		for (int i = 0; i < 9; i++) send(OP_INSERT, 16'h100 + 16'(i), 16'h100, 16'h100);
		send(OP_QUERY, 16'h0104, 16'h0100, 16'h0100);
		send(OP_CLEAR, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0);
		set_grid(0);
		send(OP_INSERT, 16'hAAAA, 16'h5555, 16'h0F0F);
		send(OP_QUERY, 16'h5555, 16'hAAAA, 16'hF0F0);
		set_grid(31);
		send(OP_QUERY, 16'h2AAA, 16'hD555, 16'h8F0F);
		send(OP_INSERT, 16'hAAAB, 16'h5556, 16'h0F10);
		send(OP_QUERY, 16'hAAAA, 16'h5555, 16'h0F0F);
		// random phases across grid sizes
		for (int ph = 0; ph < 11; ph++) begin
			if (ph == 4) idle_pct = 63;
			if (ph == 8) idle_pct = 0;
			set_grid(ph == 0 ? 5'd16 : ph == 1 ? 5'd1 : ph == 2 ? 5'd2 :
				ph == 3 ? 5'd17 : 5'($urandom_range(0, 31)));
			if (ph % 3 == 0) send(OP_CLEAR, 0, 0, 0);
			anchor[0] = 16'($urandom); anchor[1] = 16'($urandom); anchor[2] = 16'($urandom);
			for (int i = 0; i < 100; i++) rand_item();
		end
		set_grid(16);
		idle_pct = 0;
		for (int i = 0; i < 20; i++)
			send(OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom));
		drain();
		if (board.errors == 0 && board.exp_st.size() == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

	initial begin
		#400ms;
		$display("tb: errors");
		$finish;
	end
endmodule
